// File: src/dvr_pkg.sv
`default_nettype none

package dvr_pkg;

    // Request codes carried on req_type and echoed on resp_kind
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_COMPUTE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // Fixed field widths of the item ports
    localparam int TYPE_W   = 2;
    localparam int NODE_W   = 5;
    localparam int COSTIN_W = 8;
    localparam int CFG_W    = 6;
    localparam int ROUND_W  = 5;

    // Distance table word: unreachable flag over a 13-bit distance
    localparam int DIST_W = 13;
    localparam int TBL_W  = DIST_W + 1;

    localparam logic [DIST_W-1:0]  DIST_MAX  = 13'd8191;
    localparam logic [ROUND_W-1:0] ROUND_MAX = 5'd31;
    localparam logic [CFG_W-1:0]   CFG_RESET = 6'd4;

    // Control from the sequencer to the relaxation datapath
    typedef struct packed {
        logic load_cur;   // table read data is the entry being relaxed
        logic via_valid;  // table and link read data form one candidate
    } relax_ctl_t;

endpackage : dvr_pkg

`default_nettype wire

// File: src/dvr_ram.sv
`default_nettype none

module dvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule : dvr_ram

`default_nettype wire

// File: src/dvr_relax.sv
`default_nettype none

module dvr_relax
    import dvr_pkg::*;
#(
    parameter int COST_BITS = 8
) (
    input  wire logic               clk,
    input  wire relax_ctl_t         ctl,
    input  wire logic [TBL_W-1:0]   tbl_word,
    input  wire logic [COST_BITS:0] link_word,
    output logic      [TBL_W-1:0]   cur_word,
    output logic                    improved
);

    localparam int SUM_W = ((COST_BITS > DIST_W) ? COST_BITS : DIST_W) + 1;

    logic [TBL_W-1:0] cur_reg;
    logic [TBL_W-1:0] cur_next;
    logic [SUM_W-1:0] sum;
    logic [DIST_W-1:0] cand;
    logic             usable;

    // Candidate path: link cost plus the neighbor's distance, saturated
    assign sum    = SUM_W'(link_word[COST_BITS-1:0]) + SUM_W'(tbl_word[DIST_W-1:0]);
    assign cand   = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    assign usable = ctl.via_valid && link_word[COST_BITS] && !tbl_word[DIST_W];

    // Load the entry on load_cur; else take a usable candidate if the entry is unreachable or shorter
    always_comb
    begin
        improved = 1'b0;
        cur_next = cur_reg;
        if (ctl.load_cur)
        begin
            cur_next = tbl_word;
        end
        else if (usable && (cur_reg[DIST_W] || (cand < cur_reg[DIST_W-1:0])))
        begin
            cur_next = {1'b0, cand};
            improved = 1'b1;
        end
    end

    // Hold the entry under relaxation
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign cur_word = cur_next;

endmodule : dvr_relax

`default_nettype wire

// File: src/distance_vector_route_table.sv
// Channel   | Handshake          | Word
// ----------+--------------------+-----------------------------------------------
// request   | start / busy       | req_type, src_node, dst_node, link_cost, no_link
// result    | done (1-cycle)     | resp_kind, dist_value, unreachable, round_count
// config    | cfg_we             | cfg_wdata (node_count)
//
// A request is taken when start is high and busy is low; busy is the sequencer not idle.
// Write: S_IDLE then S_WR2 (one link memory port, two mirrored entries). Read: S_IDLE then S_RD.
// Compute: S_INIT seeds all n*n entries, then each pass walks every (i,j) through S_CUR,
// S_K per k and S_WB; the single table read port feeds one relaxation step per cycle.
// After reset the link memory is cleared one entry a cycle, all 4^ceil(log2(MAX_NODES))
// entries (1024 at the defaults), with busy high; config writes are taken throughout.
// Every result appears for exactly one cycle on done; the receiver cannot stall it.
`default_nettype none

module distance_vector_route_table
    import dvr_pkg::*;
#(
    parameter int MAX_NODES = 32,
    parameter int COST_BITS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [TYPE_W-1:0]   req_type,
    input  wire logic [NODE_W-1:0]   src_node,
    input  wire logic [NODE_W-1:0]   dst_node,
    input  wire logic [COSTIN_W-1:0] link_cost,
    input  wire logic                no_link,
    input  wire logic                cfg_we,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    output logic                     done,
    output logic      [TYPE_W-1:0]   resp_kind,
    output logic      [DIST_W-1:0]   dist_value,
    output logic                     unreachable,
    output logic      [ROUND_W-1:0]  round_count
);

    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int LINK_W    = COST_BITS + 1;
    localparam int EXT_W     = IDX_W + NODE_W;
    localparam int CEXT_W    = COST_BITS + COSTIN_W;
    localparam int SUM_W     = ((COST_BITS > DIST_W) ? COST_BITS : DIST_W) + 1;
    localparam int GUARD_LIM = 4 * MAX_NODES + 4;
    localparam int GUARD_W   = $clog2(GUARD_LIM + 1);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_WR2    = 10'b0000000100,
        S_RD     = 10'b0000001000,
        S_INIT   = 10'b0000010000,
        S_IDRAIN = 10'b0000100000,
        S_CUR    = 10'b0001000000,
        S_K      = 10'b0010000000,
        S_WB     = 10'b0100000000,
        S_PASS   = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [IDX_W-1:0]    i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0]    nm1_reg, nm1_next;
    logic [IDX_W-1:0]    wr_s_reg, wr_s_next, wr_d_reg, wr_d_next;
    logic [LINK_W-1:0]   wr_word_reg, wr_word_next;
    logic                rd_oor_reg, rd_oor_next;
    logic                iw_v_reg, iw_v_next;
    logic [IDX_W-1:0]    iw_i_reg, iw_i_next, iw_j_reg, iw_j_next;
    logic                rk_cur_reg, rk_cur_next, rk_via_reg, rk_via_next;
    logic                changed_reg, changed_next;
    logic [ROUND_W-1:0]  passes_reg, passes_next;
    logic [GUARD_W-1:0]  guard_reg, guard_next;
    logic [CFG_W-1:0]    node_count_reg, node_count_next;
    logic                done_reg, done_next;
    logic [TYPE_W-1:0]   kind_reg, kind_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic                unr_reg, unr_next;
    logic [ROUND_W-1:0]  round_reg, round_next;

    // Memory ports
    logic                link_we;
    logic [ADDR_W-1:0]   link_waddr, link_raddr;
    logic [LINK_W-1:0]   link_wdata, link_rdata;
    logic                tbl_we;
    logic [ADDR_W-1:0]   tbl_waddr, tbl_raddr;
    logic [TBL_W-1:0]    tbl_wdata, tbl_rdata;
    logic                tbl_rd_use;

    // Relaxation datapath
    relax_ctl_t          rctl;
    logic [TBL_W-1:0]    cur_word;
    logic                improved;

    // Input decode
    logic                accept;
    logic [EXT_W-1:0]    src_ext, dst_ext, nm1_ext;
    logic [IDX_W-1:0]    src_idx, dst_idx;
    logic [CEXT_W-1:0]   cost_ext;
    logic [LINK_W-1:0]   link_in;
    logic                wr_in_range, rd_oor;
    logic [CFG_W:0]      cfg_ext, n_clamp;
    logic [IDX_W-1:0]    nm1_cfg;

    // Seed value and loop control
    logic [SUM_W-1:0]    seed_cost;
    logic [TBL_W-1:0]    seed_word;
    logic                last_i, last_j;
    logic [GUARD_W-1:0]  guard_inc;
    logic                pass_again;

    assign accept  = start && !busy;
    assign src_ext = EXT_W'(src_node);
    assign dst_ext = EXT_W'(dst_node);
    assign src_idx = src_ext[IDX_W-1:0];
    assign dst_idx = dst_ext[IDX_W-1:0];

    assign cost_ext = CEXT_W'(link_cost);
    assign link_in  = no_link ? '0 : {1'b1, cost_ext[COST_BITS-1:0]};

    assign wr_in_range = (src_ext < EXT_W'(MAX_NODES)) && (dst_ext < EXT_W'(MAX_NODES));

    // Clamp the configured node count into 1..MAX_NODES
    assign cfg_ext = {1'b0, node_count_reg};
    always_comb
    begin
        n_clamp = cfg_ext;
        if (cfg_ext == '0)
        begin
            n_clamp = (CFG_W + 1)'(1);
        end
        else if (cfg_ext > (CFG_W + 1)'(MAX_NODES))
        begin
            n_clamp = (CFG_W + 1)'(MAX_NODES);
        end
    end
    assign nm1_cfg = IDX_W'(n_clamp - (CFG_W + 1)'(1));
    assign nm1_ext = EXT_W'(nm1_cfg);
    assign rd_oor  = (src_ext > nm1_ext) || (dst_ext > nm1_ext);

    // Seed word: zero on the diagonal, link cost where present, else unreachable
    assign seed_cost = SUM_W'(link_rdata[COST_BITS-1:0]);
    always_comb
    begin
        if (iw_i_reg == iw_j_reg)
        begin
            seed_word = '0;
        end
        else if (link_rdata[COST_BITS])
        begin
            seed_word = {1'b0, (seed_cost > SUM_W'(DIST_MAX)) ? DIST_MAX
                                                              : seed_cost[DIST_W-1:0]};
        end
        else
        begin
            seed_word = {1'b1, {DIST_W{1'b0}}};
        end
    end

    assign last_i     = (i_reg == nm1_reg);
    assign last_j     = (j_reg == nm1_reg);
    assign guard_inc  = guard_reg + GUARD_W'(1);
    assign pass_again = changed_reg && (guard_inc < GUARD_W'(GUARD_LIM));

    assign rctl.load_cur  = rk_cur_reg;
    assign rctl.via_valid = rk_via_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        nm1_next        = nm1_reg;
        wr_s_next       = wr_s_reg;
        wr_d_next       = wr_d_reg;
        wr_word_next    = wr_word_reg;
        rd_oor_next     = rd_oor_reg;
        iw_v_next       = 1'b0;
        iw_i_next       = iw_i_reg;
        iw_j_next       = iw_j_reg;
        rk_cur_next     = 1'b0;
        rk_via_next     = 1'b0;
        changed_next    = changed_reg;
        passes_next     = passes_reg;
        guard_next      = guard_reg;
        node_count_next = cfg_we ? cfg_wdata : node_count_reg;
        done_next       = 1'b0;
        kind_next       = kind_reg;
        dist_next       = dist_reg;
        unr_next        = unr_reg;
        round_next      = round_reg;

        link_we    = 1'b0;
        link_waddr = {src_idx, dst_idx};
        link_wdata = link_in;
        link_raddr = {i_reg, j_reg};
        tbl_we     = iw_v_reg;
        tbl_waddr  = {iw_i_reg, iw_j_reg};
        tbl_wdata  = seed_word;
        tbl_raddr  = {src_idx, dst_idx};
        tbl_rd_use = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the link memory to no-link
                link_we    = 1'b1;
                link_waddr = clr_reg;
                link_wdata = '0;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = req_type;
                    dist_next  = '0;
                    unr_next   = 1'b0;
                    round_next = '0;
                    case (req_type)
                        REQ_WRITE:
                        begin
                            if (wr_in_range)
                            begin
                                link_we      = 1'b1;
                                wr_s_next    = src_idx;
                                wr_d_next    = dst_idx;
                                wr_word_next = link_in;
                                state_next   = S_WR2;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        REQ_COMPUTE:
                        begin
                            nm1_next     = nm1_cfg;
                            i_next       = '0;
                            j_next       = '0;
                            passes_next  = '0;
                            guard_next   = '0;
                            changed_next = 1'b0;
                            state_next   = S_INIT;
                        end
                        REQ_READ:
                        begin
                            tbl_rd_use  = 1'b1;
                            rd_oor_next = rd_oor;
                            state_next  = S_RD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_WR2:
            begin
                // Mirror entry of the link
                link_we    = 1'b1;
                link_waddr = {wr_d_reg, wr_s_reg};
                link_wdata = wr_word_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_RD:
            begin
                done_next = 1'b1;
                if (rd_oor_reg || tbl_rdata[DIST_W])
                begin
                    unr_next = 1'b1;
                end
                else
                begin
                    dist_next = tbl_rdata[DIST_W-1:0];
                end
                state_next = S_IDLE;
            end

            S_INIT:
            begin
                // Read link (i,j); the seed word is written from the registered link read data
                iw_v_next = 1'b1;
                iw_i_next = i_reg;
                iw_j_next = j_reg;
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        i_next     = '0;
                        state_next = S_IDRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end

            S_IDRAIN:
            begin
                state_next = S_CUR;
            end

            S_CUR, S_WB:
            begin
                if (state_reg == S_CUR && (j_reg != i_reg))
                begin
                    // Fetch the entry under relaxation
                    tbl_raddr   = {i_reg, j_reg};
                    tbl_rd_use  = 1'b1;
                    rk_cur_next = 1'b1;
                    k_next      = '0;
                    state_next  = S_K;
                end
                else
                begin
                    if (state_reg == S_WB)
                    begin
                        // Write back the relaxed entry
                        tbl_we    = 1'b1;
                        tbl_waddr = {i_reg, j_reg};
                        tbl_wdata = cur_word;
                        if (improved)
                        begin
                            changed_next = 1'b1;
                        end
                    end
                    // Advance to the next (i,j)
                    if (last_j)
                    begin
                        j_next = '0;
                        if (last_i)
                        begin
                            i_next     = '0;
                            state_next = S_PASS;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = S_CUR;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = S_CUR;
                    end
                end
            end

            S_K:
            begin
                // Issue one neighbor k per cycle
                tbl_raddr   = {k_reg, j_reg};
                tbl_rd_use  = 1'b1;
                link_raddr  = {i_reg, k_reg};
                rk_via_next = (k_reg != i_reg);
                if (improved)
                begin
                    changed_next = 1'b1;
                end
                if (k_reg == nm1_reg)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end

            S_PASS:
            begin
                if (changed_reg && (passes_reg != ROUND_MAX))
                begin
                    passes_next = passes_reg + ROUND_W'(1);
                end
                guard_next   = guard_inc;
                changed_next = 1'b0;
                if (pass_again)
                begin
                    state_next = S_CUR;
                end
                else
                begin
                    done_next  = 1'b1;
                    round_next = (changed_reg && (passes_reg != ROUND_MAX))
                                 ? passes_reg + ROUND_W'(1) : passes_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            nm1_reg        <= '0;
            rd_oor_reg     <= 1'b0;
            iw_v_reg       <= 1'b0;
            iw_i_reg       <= '0;
            iw_j_reg       <= '0;
            rk_cur_reg     <= 1'b0;
            rk_via_reg     <= 1'b0;
            changed_reg    <= 1'b0;
            passes_reg     <= '0;
            guard_reg      <= '0;
            node_count_reg <= CFG_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            nm1_reg        <= nm1_next;
            rd_oor_reg     <= rd_oor_next;
            iw_v_reg       <= iw_v_next;
            iw_i_reg       <= iw_i_next;
            iw_j_reg       <= iw_j_next;
            rk_cur_reg     <= rk_cur_next;
            rk_via_reg     <= rk_via_next;
            changed_reg    <= changed_next;
            passes_reg     <= passes_next;
            guard_reg      <= guard_next;
            node_count_reg <= node_count_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wr_s_reg    <= wr_s_next;
        wr_d_reg    <= wr_d_next;
        wr_word_reg <= wr_word_next;
        kind_reg    <= kind_next;
        dist_reg    <= dist_next;
        unr_reg     <= unr_next;
        round_reg   <= round_next;
    end

    dvr_ram #(
        .WIDTH (LINK_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    dvr_ram #(
        .WIDTH (TBL_W),
        .DEPTH (DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    dvr_relax #(
        .COST_BITS (COST_BITS)
    ) u_relax (
        .clk       (clk),
        .ctl       (rctl),
        .tbl_word  (tbl_rdata),
        .link_word (link_rdata),
        .cur_word  (cur_word),
        .improved  (improved)
    );

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign resp_kind   = kind_reg;
    assign dist_value  = dist_reg;
    assign unreachable = unr_reg;
    assign round_count = round_reg;

    // A table read that matters never hits the entry written in the same cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_we && tbl_rd_use) |-> (tbl_waddr != tbl_raddr))
        else $error("table read and write hit the same entry");

    // An accepted compute keeps the block busy in the next cycle
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_COMPUTE)) |=> busy)
        else $error("compute accepted without going busy");

    // Only compute answers carry a pass count
    a_round_only_compute: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (resp_kind != REQ_COMPUTE)) |-> (round_count == '0))
        else $error("pass count on a non-compute answer");

    // An unreachable answer carries no distance
    a_unr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && unreachable) |-> (dist_value == '0))
        else $error("unreachable answer with a distance");

    // Changing passes never outnumber passes run
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS) |-> ((GUARD_W + ROUND_W)'(passes_reg)
                                   <= (GUARD_W + ROUND_W)'(guard_reg)))
        else $error("pass count exceeds passes run");

endmodule : distance_vector_route_table

`default_nettype wire
